// ===== rtl/hbf_pkg.sv =====
// Package for the harmonic bond force unit: fixed-point widths, register
// indexes and the beat payload that moves down the cell chain.
// No dependencies.
`default_nettype none

package hbf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_TYPES = 4;

  localparam int CFG_ADDR_W     = 3;
  localparam int REG_ENERGY_EN  = 0;
  localparam int REG_STIFF_BASE = 1;

  localparam int COORD_W = 32;
  localparam int MAG_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ROOT_W  = MAG_W;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int SREM_W  = ROOT_W + 2;
  localparam int KD_W    = 32 + MAG_W;
  localparam int KLO_W   = MAG_W;
  localparam int PLO_W   = KLO_W + MAG_W;
  localparam int PHI_W   = KD_W - KLO_W + MAG_W;
  localparam int PROD_W  = KD_W + MAG_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int Q_W     = 32;
  localparam int DEN_W   = ROOT_W + FRAC_BITS;
  localparam int LANES   = 4;
  localparam int NRES    = 6;

  // Chain layout: front stages, root cells, middle stages, divider cells,
  // one output stage.
  localparam int N_FRONT   = 3;
  localparam int SQ_STEPS  = ROOT_W;
  localparam int N_MID     = 4;
  localparam int DIV_STEPS = Q_W;
  localparam int SQ0  = N_FRONT;
  localparam int MID0 = SQ0 + SQ_STEPS;
  localparam int DIV0 = MID0 + N_MID;
  localparam int OUT0 = DIV0 + DIV_STEPS;
  localparam int NST  = OUT0 + 1;

  typedef struct packed {
    logic [2:0][COORD_W-1:0]  pa;
    logic [2:0][COORD_W-1:0]  pb;
    logic [2:0][MAG_W-1:0]    mag;
    logic [2:0]               neg;
    logic [31:0]              rest;
    logic [1:0]               kind;
    logic                     fin;
    logic [2:0][SQ_W-1:0]     sq;
    logic [RAD_W-1:0]         rad;
    logic [SREM_W-1:0]        srem;
    logic [ROOT_W-1:0]        root;
    logic                     captured;
    logic [ROOT_W-1:0]        r0;
    logic [ROOT_W-1:0]        drmag;
    logic                     drneg;
    logic [31:0]              kval;
    logic [KD_W-1:0]          kd;
    logic [LANES-1:0][PLO_W-1:0] plo;
    logic [LANES-1:0][PHI_W-1:0] phi;
    logic [LANES-1:0]         sgn;
    logic [LANES-1:0][Q_W-1:0]   nlo;
    logic [LANES-1:0][DEN_W-1:0] drem;
    logic [LANES-1:0][DEN_W-1:0] den;
    logic [LANES-1:0][Q_W-1:0]   q;
    logic [LANES-1:0]         ovf;
    logic [31:0]              energy;
    logic [NRES-1:0][31:0]    res;
  } pl_t;

endpackage

`default_nettype wire

// ===== rtl/hbf_sqrt_cell.sv =====
// One cell of the square root chain: settles one bit of the bond length.
// Depends on hbf_pkg.
`default_nettype none

module hbf_sqrt_cell import hbf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  pl_t  up_pl,
  output logic dn_valid,
  input  logic dn_ready,
  output pl_t  dn_pl
);

  logic v_r;
  pl_t  pl_r;
  pl_t  pl_nxt;
  logic en;
  logic [SREM_W+1:0] t;
  logic [SREM_W+1:0] trial;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_pl    = pl_r;

  // Bring down the next two radicand bits and try a one in the root.
  always_comb begin
    pl_nxt = up_pl;
    t      = {up_pl.srem, up_pl.rad[RAD_W-1 -: 2]};
    trial  = (SREM_W+2)'({up_pl.root, 2'b01});
    pl_nxt.rad = {up_pl.rad[RAD_W-3:0], 2'b00};
    if (t >= trial) begin
      pl_nxt.srem = SREM_W'(t - trial);
      pl_nxt.root = {up_pl.root[ROOT_W-2:0], 1'b1};
    end else begin
      pl_nxt.srem = t[SREM_W-1:0];
      pl_nxt.root = {up_pl.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hbf_div_cell.sv =====
// One cell of the divider chain: one quotient bit for each of the four lanes
// (three force components and the scalar force). Depends on hbf_pkg.
`default_nettype none

module hbf_div_cell import hbf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  pl_t  up_pl,
  output logic dn_valid,
  input  logic dn_ready,
  output pl_t  dn_pl
);

  logic v_r;
  pl_t  pl_r;
  pl_t  pl_nxt;
  logic en;
  logic [LANES-1:0][DEN_W:0] t;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_pl    = pl_r;

  always_comb begin
    pl_nxt = up_pl;
    for (int c = 0; c < LANES; c++) begin
      t[c] = {up_pl.drem[c], up_pl.nlo[c][Q_W-1]};
      pl_nxt.nlo[c] = {up_pl.nlo[c][Q_W-2:0], 1'b0};
      if (t[c] >= {1'b0, up_pl.den[c]}) begin
        pl_nxt.drem[c] = DEN_W'(t[c] - {1'b0, up_pl.den[c]});
        pl_nxt.q[c]    = {up_pl.q[c][Q_W-2:0], 1'b1};
      end else begin
        pl_nxt.drem[c] = t[c][DEN_W-1:0];
        pl_nxt.q[c]    = {up_pl.q[c][Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/harmonic_bond_force_unit.sv =====
// Harmonic bond force unit: top level with the configuration registers,
// the arithmetic stages and the chains of root and divider cells.
// Depends on hbf_pkg, hbf_sqrt_cell and hbf_div_cell.
`default_nettype none

// Takes one bond per clock while the output side does not stall and returns
// one result beat per bond, in order, after it has passed through the whole
// length of the cell chain: three front stages
// (separation, squares, sum), 33 square root cells (one length bit each),
// four middle stages (rest length, stiffness product, partial products,
// divider setup), 32 divider cells (one quotient bit each) and the output
// register. Every stage holds its beat while the next one is full, so a
// result that waits at the output stalls only as many beats as are queued
// behind it; a bond is taken whenever any stage has room. Configuration
// writes are always accepted and must only be made while no bond is inside.
module harmonic_bond_force_unit import hbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, rest_length
  input  logic [223:0]          in_tdata,
  // bond_kind
  input  logic [1:0]            in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // force_x, force_y, force_z, force_scalar, bond_energy, rest_used
  output logic [191:0]          out_tdata,
  // rest_captured
  output logic                  out_tuser,
  output logic                  out_tlast
);

  localparam int OP_DIFF    = 0;
  localparam int OP_SQUARE  = 1;
  localparam int OP_SUM     = 2;
  localparam int OP_LEN     = 3;
  localparam int OP_KD      = 4;
  localparam int OP_PART    = 5;
  localparam int OP_DIVINIT = 6;
  localparam int OP_OUT     = 7;

  logic                        een_r;
  logic [NUM_TYPES-1:0][31:0]  stiff_r;

  logic lv [0:NST];
  logic lr [0:NST];
  pl_t  lp [0:NST];

  function automatic logic [31:0] sat32(input logic [Q_W-1:0] q, input logic ovf,
                                        input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    end else begin
      r = (ovf || q[Q_W-1]) ? 32'h7fff_ffff : q;
    end
    return r;
  endfunction

  function automatic pl_t stage_fn(input int op, input pl_t p,
                                   input logic [NUM_TYPES-1:0][31:0] kt, input logic een);
    pl_t                      o;
    logic signed [MAG_W-1:0]  d;
    logic [MAG_W-1:0]         m;
    logic [PROD_W-1:0]        prod;
    logic [NUM_W-1:0]         num;
    logic [NUM_W-33:0]        top;
    logic [DEN_W-1:0]         den;
    o = p;
    unique case (op)
      OP_DIFF: begin
        for (int c = 0; c < 3; c++) begin
          d = $signed({p.pa[c][COORD_W-1], p.pa[c]}) - $signed({p.pb[c][COORD_W-1], p.pb[c]});
          o.neg[c] = d[MAG_W-1];
          o.mag[c] = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
        end
      end
      OP_SQUARE: begin
        for (int c = 0; c < 3; c++) begin
          o.sq[c] = SQ_W'(p.mag[c]) * SQ_W'(p.mag[c]);
        end
      end
      OP_SUM: begin
        o.rad  = p.sq[0] + p.sq[1] + p.sq[2];
        o.srem = '0;
        o.root = '0;
      end
      OP_LEN: begin
        // An unset rest length takes the current length.
        o.captured = (p.rest == 32'd0);
        o.r0       = o.captured ? p.root : ROOT_W'(p.rest);
        o.drneg    = p.root < o.r0;
        o.drmag    = o.drneg ? (o.r0 - p.root) : (p.root - o.r0);
        o.kval     = (int'(p.kind) < NUM_TYPES) ? kt[p.kind] : 32'd0;
      end
      OP_KD: begin
        o.kd = KD_W'(p.kval) * KD_W'(p.drmag);
      end
      OP_PART: begin
        // Lanes 0..2 scale the separation, lane 3 forms the energy product.
        for (int c = 0; c < LANES; c++) begin
          m = (c < 3) ? p.mag[c] : p.drmag;
          o.plo[c] = PLO_W'(p.kd[KLO_W-1:0]) * PLO_W'(m);
          o.phi[c] = PHI_W'(p.kd[KD_W-1:KLO_W]) * PHI_W'(m);
        end
      end
      OP_DIVINIT: begin
        for (int c = 0; c < LANES; c++) begin
          prod = {p.phi[c], {KLO_W{1'b0}}} + PROD_W'(p.plo[c]);
          if (c < 3) begin
            num      = {prod, 1'b0};
            den      = {p.root, {FRAC_BITS{1'b0}}};
            o.sgn[c] = !p.drneg ^ p.neg[c];
          end else begin
            num      = NUM_W'({p.kd, 1'b0});
            den      = DEN_W'(p.root);
            o.sgn[c] = !p.drneg;
            if (|prod[PROD_W-1:2*FRAC_BITS+32]) begin
              o.energy = 32'hffff_ffff;
            end else begin
              o.energy = prod[2*FRAC_BITS+31:2*FRAC_BITS];
            end
          end
          // A quotient of 2^32 or more saturates; the cells then run on zero.
          top       = num[NUM_W-1:Q_W];
          o.den[c]  = den;
          o.ovf[c]  = top >= (NUM_W-32)'(den);
          o.drem[c] = o.ovf[c] ? '0 : top[DEN_W-1:0];
          o.nlo[c]  = num[Q_W-1:0];
          o.q[c]    = '0;
        end
      end
      OP_OUT: begin
        for (int c = 0; c < LANES; c++) begin
          o.res[c] = (p.root == '0) ? 32'd0 : sat32(p.q[c], p.ovf[c], p.sgn[c]);
        end
        o.res[4] = een ? p.energy : 32'd0;
        o.res[5] = p.r0[ROOT_W-1] ? 32'hffff_ffff : p.r0[31:0];
      end
      default: o = p;
    endcase
    return o;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      een_r   <= 1'b0;
      stiff_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_addr == CFG_ADDR_W'(REG_ENERGY_EN)) begin
        een_r <= cfg_data[0];
      end
      for (int t = 0; t < NUM_TYPES; t++) begin
        if (cfg_addr == CFG_ADDR_W'(REG_STIFF_BASE + t)) begin
          stiff_r[t] <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    lp[0] = '0;
    for (int c = 0; c < 3; c++) begin
      lp[0].pa[c] = in_tdata[32*c +: 32];
      lp[0].pb[c] = in_tdata[32*(c+3) +: 32];
    end
    lp[0].rest = in_tdata[192 +: 32];
    lp[0].kind = in_tuser;
    lp[0].fin  = in_tlast;
  end

  assign lv[0]     = in_tvalid;
  assign in_tready = lr[0];
  assign lr[NST]   = out_tready;

  for (genvar s = 0; s < NST; s++) begin : g_stg
    if (s >= SQ0 && s < MID0) begin : g_sqrt
      hbf_sqrt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (lv[s]),
        .up_ready (lr[s]),
        .up_pl    (lp[s]),
        .dn_valid (lv[s+1]),
        .dn_ready (lr[s+1]),
        .dn_pl    (lp[s+1])
      );
    end else if (s >= DIV0 && s < OUT0) begin : g_div
      hbf_div_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (lv[s]),
        .up_ready (lr[s]),
        .up_pl    (lp[s]),
        .dn_valid (lv[s+1]),
        .dn_ready (lr[s+1]),
        .dn_pl    (lp[s+1])
      );
    end else begin : g_arith
      localparam int OP = (s < SQ0) ? s : ((s < DIV0) ? (s - MID0 + OP_LEN) : OP_OUT);
      logic v_r;
      pl_t  p_r;
      logic en;

      assign en      = !v_r || lr[s+1];
      assign lr[s]   = en;
      assign lv[s+1] = v_r;
      assign lp[s+1] = p_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r <= 1'b0;
        end else if (en) begin
          v_r <= lv[s];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          p_r <= stage_fn(OP, lp[s], stiff_r, een_r);
        end
      end
    end
  end

  assign out_tvalid = lv[NST];
  assign out_tdata  = lp[NST].res;
  assign out_tuser  = lp[NST].captured;
  assign out_tlast  = lp[NST].fin;

endmodule

`default_nettype wire

// ===== tb/hbf_checker.sv =====
// Scoreboard for the harmonic bond force unit: watches the bond, result and
// register channels, predicts every result beat and compares it field by field.
// Depends on hbf_pkg.
`timescale 1ns / 100ps

module hbf_checker import hbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [223:0]          in_tdata,
  input  logic [1:0]            in_tuser,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [191:0]          out_tdata,
  input  logic                  out_tuser,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [191:0] data;
    logic         captured;
    logic         last;
  } bond_result_t;

  logic        energy_on;
  logic [31:0] stiff [NUM_TYPES];
  bond_result_t force_queue [$];

  function automatic logic [31:0] clamp_signed(logic [127:0] mag, logic neg);
    if (neg) begin
      if (mag > 128'h8000_0000) return 32'h8000_0000;
      return 32'(-mag);
    end
    if (mag > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic bond_result_t predict_bond(logic [223:0] d, logic [1:0] kind,
                                                logic fin);
    bond_result_t res;
    logic signed [33:0] diff [3];
    logic [32:0]  mag [3];
    logic [127:0] sum, cand, kd, twokd, q, e;
    logic [63:0]  r, r0, drmag, k;
    logic         drneg, fneg, captured;
    logic [31:0]  f [4];
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      diff[c] = 34'($signed(d[32*c +: 32])) - 34'($signed(d[32*(c+3) +: 32]));
      mag[c] = diff[c] < 0 ? 33'(-diff[c]) : 33'(diff[c]);
      sum += 128'(mag[c]) * 128'(mag[c]);
    end
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = 128'(r | (64'd1 << b));
      if (cand * cand <= sum) r = r | (64'd1 << b);
    end
    r0 = 64'(d[223:192]);
    captured = (r0 == 0);
    if (captured) r0 = r;
    drneg = r < r0;
    drmag = drneg ? r0 - r : r - r0;
    k = (kind < NUM_TYPES) ? 64'(stiff[kind]) : '0;
    kd = 128'(k) * 128'(drmag);
    twokd = kd << 1;
    fneg = !drneg;
    for (int c = 0; c < 4; c++) f[c] = '0;
    if (r != 0) begin
      for (int c = 0; c < 3; c++) begin
        q = (twokd * 128'(mag[c])) / (128'(r) << FRAC_BITS);
        f[c] = clamp_signed(q, fneg != (diff[c] < 0));
      end
      f[3] = clamp_signed(twokd / 128'(r), fneg);
    end
    e = (kd * 128'(drmag)) >> (2 * FRAC_BITS);
    res.data = {(r0 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r0[31:0],
                energy_on ? ((e > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0]) : 32'h0,
                f[3], f[2], f[1], f[0]};
    res.captured = captured;
    res.last = fin;
    return res;
  endfunction

  always @(posedge clk) begin
    bond_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      energy_on <= 1'b0;
      for (int i = 0; i < NUM_TYPES; i++) stiff[i] <= '0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == REG_ENERGY_EN) energy_on <= cfg_data[0];
        else if (cfg_addr >= REG_STIFF_BASE && cfg_addr < REG_STIFF_BASE + NUM_TYPES)
          stiff[cfg_addr - REG_STIFF_BASE] <= cfg_data;
      end
      if (in_tvalid && in_tready)
        force_queue.push_back(predict_bond(in_tdata, in_tuser, in_tlast));
      if (out_tvalid && out_tready) begin
        if (force_queue.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, got %h", $time, out_tdata);
          errs++;
        end else begin
          want = force_queue.pop_front();
          for (int c = 0; c < 6; c++)
            if (out_tdata[32*c +: 32] !== want.data[32*c +: 32]) begin
              $display("%0t: field %0d: expected %h, got %h", $time, c,
                       want.data[32*c +: 32], out_tdata[32*c +: 32]);
              errs++;
            end
          if (out_tuser !== want.captured || out_tlast !== want.last) begin
            $display("%0t: captured/last: expected %b%b, got %b%b", $time,
                     want.captured, want.last, out_tuser, out_tlast);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending_count <= force_queue.size();
  end

endmodule

// ===== tb/tb_harmonic_bond_force_unit.sv =====
// Top of the harmonic bond force unit testbench: clock, reset, register
// settings, bond stimulus, watchdog and verdict.
// Depends on hbf_pkg, harmonic_bond_force_unit and hbf_checker.
`timescale 1ns / 100ps

module tb_harmonic_bond_force_unit;
  import hbf_pkg::*;

  localparam int LATENCY = 73;
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [31:0]           cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [223:0]          in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [191:0]          out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  int                    fail_count;
  int                    pending_count;
  int                    idle_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  harmonic_bond_force_unit uut (.*);

  hbf_checker scoreboard (.*);

  // Receiver: a fresh random stall before each result beat.
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= CFG_ADDR_W'(idx);
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_pipe();
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Sender; a gap of zero keeps in_tvalid high across beats.
  task automatic send_bond(input logic [31:0] p [6], input logic [31:0] rest,
                           input logic [1:0] kind, input logic fin, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rest, p[5], p[4], p[3], p[2], p[1], p[0]};
    in_tuser  <= kind;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(input int style);
    case (style)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
      default: return 32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
    endcase
  endfunction

  initial begin
    logic [31:0] p [6];
    logic [31:0] rest;
    logic [31:0] kset [4];
    int style;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes and each special case, energy on, mixed stiffness.
    write_reg(REG_ENERGY_EN, 32'd1);
    write_reg(REG_STIFF_BASE + 0, 32'hFFFF_FFFF);
    write_reg(REG_STIFF_BASE + 1, 32'h0001_0000);
    write_reg(REG_STIFF_BASE + 2, 32'h0000_0001);
    write_reg(REG_STIFF_BASE + 3, 32'h0);
    for (int i = 0; i < 6; i++) p[i] = '0;
    send_bond(p, 32'h0001_0000, 2'd0, 1'b0, 1'b0);    // zero length
    send_bond(p, 32'h0, 2'd1, 1'b0, 1'b0);            // zero length, unset rest
    p[0] = 32'h7FFF_FFFF; p[3] = 32'h8000_0000;
    send_bond(p, 32'h0, 2'd0, 1'b0, 1'b0);            // captured length, widest x separation
    send_bond(p, 32'h1, 2'd0, 1'b1, 1'b0);
    p[1] = 32'h8000_0000; p[4] = 32'h7FFF_FFFF;
    p[2] = 32'h7FFF_FFFF; p[5] = 32'h8000_0000;
    send_bond(p, 32'hFFFF_FFFF, 2'd0, 1'b0, 1'b0);
    send_bond(p, 32'h1, 2'd3, 1'b0, 1'b0);            // no stiffness
    for (int i = 0; i < 6; i++) p[i] = '0;
    p[0] = 32'h0003_0000; p[4] = 32'h0004_0000;
    for (int kd = 0; kd < 4; kd++) begin
      send_bond(p, 32'h0002_0000, 2'(kd), 1'b0, 1'b1); // stretched
      send_bond(p, 32'h0009_0000, 2'(kd), 1'(kd == 3), 1'b1); // compressed
    end
    p[0] = 32'h1; p[4] = 32'h0;
    send_bond(p, 32'hFFFF_FFFF, 2'd0, 1'b1, 1'b0);    // tiny length
    stop_sending();
    drain_pipe();                                     // sender waits for all results

    // Random phases, each with its own register settings.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_ENERGY_EN, 32'(phase % 2));
      for (int t = 0; t < 4; t++) begin
        case ((phase + t) % 4)
          0: kset[t] = $urandom();
          1: kset[t] = $urandom_range(0, 32'h0010_0000);
          2: kset[t] = (phase == 5) ? 32'h0 : 32'hFFFF_FFFF;
          default: kset[t] = $urandom_range(0, 255);
        endcase
        write_reg(REG_STIFF_BASE + t, kset[t]);
      end
      for (int n = 0; n < 215; n++) begin
        style = $urandom_range(0, 2);
        for (int i = 0; i < 6; i++) p[i] = rand_coord(style);
        case ($urandom_range(0, 5))
          0: rest = 32'h0;
          1: rest = 32'hFFFF_FFFF;
          2: rest = $urandom_range(1, 32'h0100_0000);
          default: rest = $urandom();
        endcase
        if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) p[i + 3] = p[i];
        send_bond(p, rest, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 7) == 0),
                  phase == 2 && n < 100);
      end
      stop_sending();
      drain_pipe();
    end

    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hbf_pkg.sv
rtl/hbf_sqrt_cell.sv
rtl/hbf_div_cell.sv
rtl/harmonic_bond_force_unit.sv
tb/hbf_checker.sv
tb/tb_harmonic_bond_force_unit.sv
